@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define CIS_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CIS_ASSERT_CLK(label, prop, msg) `CIS_ASSERT(label, clk, arst_n, prop, msg)

`endif

@@ hw/rtl/cis_pkg.sv @@
// Package of constants, types and helpers for the contact impulse solver.
package cis_pkg;

	localparam int MAX_BODIES = 256;
	localparam int FRAC_BITS  = 16;
	localparam int ADDR_W     = $clog2(MAX_BODIES);

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIVD_W = 64;
	localparam int SATW   = 68;
	localparam int ACC_W  = 54;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERCENT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOP       = 2'd2;

	localparam logic [16:0] RESET_PERCENT = 17'd13107;
	localparam logic [16:0] RESET_SLOP    = 17'd655;

	localparam logic [2:0] CMD_LOAD_V    = 3'd0;
	localparam logic [2:0] CMD_LOAD_P    = 3'd1;
	localparam logic [2:0] CMD_LOAD_PROP = 3'd2;
	localparam logic [2:0] CMD_SOLVE     = 3'd3;
	localparam logic [2:0] CMD_READ_V    = 3'd4;
	localparam logic [2:0] CMD_READ_P    = 3'd5;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SEP  = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	typedef logic signed [31:0] q_t;
	typedef q_t [2:0] vec_t;

	typedef struct packed {
		vec_t v;
		vec_t p;
		q_t   inv_mass;
		q_t   rest;
		logic stat;
	} body_t;

	localparam int BODY_W = $bits(body_t);

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic q_t sat32(input logic signed [SATW-1:0] v);
		q_t r;
		if (v[SATW-1:31] == '0 || v[SATW-1:31] == '1) begin
			r = v[31:0];
		end else if (v[SATW-1]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word and register one read word each cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/cis_div.sv @@
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
module cis_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [cis_pkg::DIVD_W-1:0]     dividend,
	input  logic signed [cis_pkg::MUL_W-1:0]      divisor,
	output logic                                  done,
	output logic signed [cis_pkg::DIVD_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(cis_pkg::DIVD_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [cis_pkg::DIVD_W-1:0]    num_q;
	logic [cis_pkg::DIVD_W-1:0]    quo_q;
	logic [cis_pkg::MUL_W:0]       rem_q;
	logic [cis_pkg::MUL_W-1:0]     dmag_q;
	logic                          neg_q;
	logic signed [cis_pkg::DIVD_W-1:0] quot_q;

	logic [cis_pkg::MUL_W:0]       rem_sh;
	logic [cis_pkg::MUL_W:0]       rem_n;
	logic                          fits;
	logic [cis_pkg::DIVD_W-1:0]    quo_n;

	// Shift in one dividend bit and try one subtract.
	always_comb begin
		rem_sh = {rem_q[cis_pkg::MUL_W-1:0], num_q[cis_pkg::DIVD_W-1]};
		fits   = rem_sh >= {1'b0, dmag_q};
		rem_n  = fits ? rem_sh - {1'b0, dmag_q} : rem_sh;
		quo_n  = {quo_q[cis_pkg::DIVD_W-2:0], fits};
	end

	// Count the steps and flag the finished quotient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(cis_pkg::DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Take magnitudes at start, iterate, then restore the sign.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend[cis_pkg::DIVD_W-1] ? cis_pkg::DIVD_W'(-dividend)
			                                      : cis_pkg::DIVD_W'(dividend);
			dmag_q <= divisor[cis_pkg::MUL_W-1] ? cis_pkg::MUL_W'(-divisor)
			                                    : cis_pkg::MUL_W'(divisor);
			neg_q  <= dividend[cis_pkg::DIVD_W-1] ^ divisor[cis_pkg::MUL_W-1];
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[cis_pkg::DIVD_W-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (cnt_q == '0) begin
				quot_q <= neg_q ? -$signed(quo_n) : $signed(quo_n);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

@@ hw/rtl/contact_impulse_solver_top.sv @@
// Top level of the contact impulse solver: body table, sequencer and datapath.
//
// Usage: pulse start with cmd, index_a, index_b, value_x/y/z and penetration
// while busy is low; the word is taken at that edge. Exactly one result word
// follows on out_x/out_y/out_z/status, marked by done for one cycle. The
// receiver cannot hold results off, so nothing stalls on the output side.
// A bad index or an unused command answers in the cycle after accept. Loads
// and reads answer from S_A, which takes the table read and, for a load,
// writes the merged entry. A solve reads both bodies, accumulates the normal
// velocity on one shared 33x33 multiplier, then runs up to seven quotients
// through a bit-serial divider of 64 steps each: none when separating or at
// zero mass sum, seven when both bodies move, four when one is static and
// one when both are static. The next command may start at the edge where
// done is high. Configuration (cfg_we, cfg_index, cfg_data) must be written
// by the user only while idle; the block itself does not enforce it.
// Reset clears the sequencer and loads the register defaults; the body table
// holds no reset value and must be loaded before use.
module contact_impulse_solver_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        cmd,
	input  logic [7:0]                        index_a,
	input  logic [7:0]                        index_b,
	input  logic signed [31:0]                value_x,
	input  logic signed [31:0]                value_y,
	input  logic signed [31:0]                value_z,
	input  logic signed [31:0]                penetration,
	input  logic                              cfg_we,
	input  logic [cis_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cis_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic signed [31:0]                out_x,
	output logic signed [31:0]                out_y,
	output logic signed [31:0]                out_z,
	output logic [1:0]                        status
);

	typedef enum logic [3:0] {
		S_IDLE, S_A, S_B, S_VN, S_CHK, S_J, S_C, S_IMP,
		S_CV, S_VA, S_PA, S_SAME, S_VB, S_PB, S_WA, S_WB
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	logic [1:0] ph_q;
	logic       done_q;
	logic [1:0] status_q;
	cis_pkg::q_t out_x_q, out_y_q, out_z_q;

	logic [8:0]  body_count_q;
	logic [16:0] percent_q;
	logic [16:0] slop_q;

	logic [2:0]       cmd_q;
	logic [7:0]       ia_q, ib_q;
	cis_pkg::vec_t    n_q;
	cis_pkg::q_t      pen_q;
	cis_pkg::body_t   a_q, b_q;
	cis_pkg::vec_t    dv_q, imp_q, cv_q;
	logic signed [cis_pkg::ACC_W-1:0]  acc_q;
	logic signed [cis_pkg::MUL_W-1:0]  msum_q, neg_vn_q, over_q;
	cis_pkg::q_t      gain_q, j_q, c_q;
	logic signed [cis_pkg::PROD_W-1:0] prod_s1;

	logic                            ram_we;
	logic [cis_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [cis_pkg::BODY_W-1:0]      ram_wdata, ram_rdata;
	cis_pkg::body_t                  rd_body, merged;

	logic signed [cis_pkg::MUL_W-1:0]  mul_a, mul_b;
	cis_pkg::q_t                       fmul_w, qsat_w, vn_w, gain_w, e_w;
	logic signed [cis_pkg::MUL_W-1:0]  msum_w, over_w;
	logic signed [cis_pkg::SATW-1:0]   diff_w;
	logic                              ok_a, ok_b, accept;
	logic                              div_start, div_done;
	logic signed [cis_pkg::DIVD_W-1:0] div_quot;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign ok_a   = (9'(index_a) < body_count_q) && (32'(index_a) < cis_pkg::MAX_BODIES);
	assign ok_b   = (9'(index_b) < body_count_q) && (32'(index_b) < cis_pkg::MAX_BODIES);

	// Body table: one wide entry per body.
	cis_ram #(
		.WIDTH(cis_pkg::BODY_W),
		.DEPTH(cis_pkg::MAX_BODIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_body   = ram_rdata;
	assign ram_raddr = (state_q == S_IDLE) ? cis_pkg::ADDR_W'(index_a)
	                                       : cis_pkg::ADDR_W'(ib_q);

	// Merge a load into the entry just read.
	always_comb begin
		merged = rd_body;
		case (cmd_q)
			cis_pkg::CMD_LOAD_V: merged.v = n_q;
			cis_pkg::CMD_LOAD_P: merged.p = n_q;
			cis_pkg::CMD_LOAD_PROP: begin
				merged.inv_mass = n_q[0];
				merged.rest     = n_q[1];
				merged.stat     = (n_q[2] != '0);
			end
			default: merged = rd_body;
		endcase
	end

	// Drive the table write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cis_pkg::ADDR_W'(ia_q);
		ram_wdata = merged;
		case (state_q)
			S_A: ram_we = (cmd_q == cis_pkg::CMD_LOAD_V) || (cmd_q == cis_pkg::CMD_LOAD_P) ||
			              (cmd_q == cis_pkg::CMD_LOAD_PROP);
			S_WA: begin
				ram_we    = 1'b1;
				ram_wdata = a_q;
			end
			S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = cis_pkg::ADDR_W'(ib_q);
				ram_wdata = b_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Select the operands of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_VN: begin
				mul_a = cis_pkg::MUL_W'(dv_q[k_q]);
				mul_b = cis_pkg::MUL_W'(n_q[k_q]);
			end
			S_J: begin
				mul_a = cis_pkg::MUL_W'(gain_q);
				mul_b = neg_vn_q;
			end
			S_C: begin
				mul_a = over_q;
				mul_b = $signed(cis_pkg::MUL_W'(percent_q));
			end
			S_IMP: begin
				mul_a = cis_pkg::MUL_W'(n_q[k_q]);
				mul_b = cis_pkg::MUL_W'(j_q);
			end
			S_CV: begin
				mul_a = cis_pkg::MUL_W'(n_q[k_q]);
				mul_b = cis_pkg::MUL_W'(c_q);
			end
			S_VA: begin
				mul_a = cis_pkg::MUL_W'(imp_q[k_q]);
				mul_b = cis_pkg::MUL_W'(a_q.inv_mass);
			end
			S_VB: begin
				mul_a = cis_pkg::MUL_W'(imp_q[k_q]);
				mul_b = cis_pkg::MUL_W'(b_q.inv_mass);
			end
			S_PA: begin
				mul_a = cis_pkg::MUL_W'(cv_q[k_q]);
				mul_b = cis_pkg::MUL_W'(a_q.inv_mass);
			end
			S_PB: begin
				mul_a = cis_pkg::MUL_W'(cv_q[k_q]);
				mul_b = cis_pkg::MUL_W'(b_q.inv_mass);
			end
			default: mul_a = '0;
		endcase
	end

	// Derived values of the solve.
	always_comb begin
		fmul_w = cis_pkg::sat32(cis_pkg::SATW'(prod_s1 >>> cis_pkg::FRAC_BITS));
		qsat_w = cis_pkg::sat32(cis_pkg::SATW'(div_quot));
		vn_w   = cis_pkg::sat32(cis_pkg::SATW'(acc_q));
		msum_w = cis_pkg::MUL_W'($signed(a_q.inv_mass)) + cis_pkg::MUL_W'($signed(b_q.inv_mass));
		e_w    = ($signed(a_q.rest) < $signed(b_q.rest)) ? a_q.rest : b_q.rest;
		gain_w = cis_pkg::sat32(cis_pkg::SATW'($signed(e_w)) +
		                        $signed(cis_pkg::SATW'(1) << cis_pkg::FRAC_BITS));
		diff_w = cis_pkg::SATW'(pen_q) - $signed(cis_pkg::SATW'(slop_q));
		over_w = diff_w[cis_pkg::SATW-1] ? '0 : diff_w[cis_pkg::MUL_W-1:0];
	end

	assign div_start = (ph_q == 2'd1) &&
	                   ((state_q == S_J) || (state_q == S_PA) || (state_q == S_PB));

	// Shared quotient unit.
	cis_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend($signed(prod_s1[cis_pkg::DIVD_W-1:0])),
		.divisor (msum_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// Hold the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_count_q <= '0;
			percent_q    <= cis_pkg::RESET_PERCENT;
			slop_q       <= cis_pkg::RESET_SLOP;
		end else if (cfg_we) begin
			case (cfg_index)
				cis_pkg::CFG_BODY_COUNT: body_count_q <= cfg_data[8:0];
				cis_pkg::CFG_PERCENT:    percent_q    <= cfg_data;
				cis_pkg::CFG_SLOP:       slop_q       <= cfg_data;
				default:                 body_count_q <= body_count_q;
			endcase
		end
	end

	// Sequence the commands and register the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			ph_q     <= '0;
			done_q   <= 1'b0;
			status_q <= cis_pkg::ST_DONE;
			out_x_q  <= '0;
			out_y_q  <= '0;
			out_z_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						out_x_q <= '0;
						out_y_q <= '0;
						out_z_q <= '0;
						case (cmd)
							cis_pkg::CMD_LOAD_V, cis_pkg::CMD_LOAD_P, cis_pkg::CMD_LOAD_PROP,
							cis_pkg::CMD_READ_V, cis_pkg::CMD_READ_P: begin
								if (ok_a) begin
									state_q <= S_A;
								end else begin
									done_q   <= 1'b1;
									status_q <= cis_pkg::ST_BAD;
								end
							end
							cis_pkg::CMD_SOLVE: begin
								if (ok_a && ok_b) begin
									state_q <= S_A;
								end else begin
									done_q   <= 1'b1;
									status_q <= cis_pkg::ST_BAD;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= cis_pkg::ST_DONE;
							end
						endcase
					end
				end
				S_A: begin
					if (cmd_q == cis_pkg::CMD_SOLVE) begin
						state_q <= S_B;
					end else begin
						done_q   <= 1'b1;
						status_q <= cis_pkg::ST_DONE;
						state_q  <= S_IDLE;
						if (cmd_q == cis_pkg::CMD_READ_V) begin
							out_x_q <= rd_body.v[0];
							out_y_q <= rd_body.v[1];
							out_z_q <= rd_body.v[2];
						end else if (cmd_q == cis_pkg::CMD_READ_P) begin
							out_x_q <= rd_body.p[0];
							out_y_q <= rd_body.p[1];
							out_z_q <= rd_body.p[2];
						end
					end
				end
				S_B: begin
					state_q <= S_VN;
					k_q     <= '0;
					ph_q    <= '0;
				end
				S_VN, S_IMP, S_CV, S_VA, S_VB: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							case (state_q)
								S_VN:    state_q <= S_CHK;
								S_IMP:   state_q <= S_CV;
								S_CV:    state_q <= S_VA;
								S_VA:    state_q <= S_PA;
								default: state_q <= S_PB;
							endcase
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_CHK: begin
					if (vn_w > 0) begin
						done_q   <= 1'b1;
						status_q <= cis_pkg::ST_SEP;
						state_q  <= S_IDLE;
					end else if (msum_w == '0) begin
						done_q   <= 1'b1;
						status_q <= cis_pkg::ST_ZERO;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_J;
						ph_q    <= '0;
					end
				end
				S_J: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 1'b1;
					end else if (div_done) begin
						ph_q    <= '0;
						state_q <= S_C;
					end
				end
				S_C: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q    <= '0;
						k_q     <= '0;
						state_q <= S_IMP;
					end
				end
				S_PA, S_PB: begin
					if ((state_q == S_PA) ? a_q.stat : b_q.stat) begin
						ph_q    <= '0;
						k_q     <= '0;
						state_q <= (state_q == S_PA) ? S_SAME : S_WA;
					end else if (ph_q != 2'd2) begin
						ph_q <= ph_q + 1'b1;
					end else if (div_done) begin
						ph_q <= '0;
						if (k_q == 2'd2) begin
							k_q     <= '0;
							state_q <= (state_q == S_PA) ? S_SAME : S_WA;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_SAME: state_q <= S_VB;
				S_WA:   state_q <= S_WB;
				S_WB: begin
					done_q   <= 1'b1;
					status_q <= cis_pkg::ST_DONE;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture operands, body entries and partial results.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (accept) begin
			cmd_q  <= cmd;
			ia_q   <= index_a;
			ib_q   <= index_b;
			n_q[0] <= value_x;
			n_q[1] <= value_y;
			n_q[2] <= value_z;
			pen_q  <= penetration;
		end
		case (state_q)
			S_A: a_q <= rd_body;
			S_B: begin
				b_q   <= rd_body;
				acc_q <= '0;
				for (int i = 0; i < 3; i++) begin
					dv_q[i] <= cis_pkg::sat32(cis_pkg::SATW'($signed(rd_body.v[i])) -
					                          cis_pkg::SATW'($signed(a_q.v[i])));
				end
			end
			S_VN: begin
				if (ph_q == 2'd1) begin
					acc_q <= acc_q + cis_pkg::ACC_W'(prod_s1 >>> cis_pkg::FRAC_BITS);
				end
			end
			S_CHK: begin
				msum_q   <= msum_w;
				neg_vn_q <= -cis_pkg::MUL_W'(vn_w);
				gain_q   <= gain_w;
				over_q   <= over_w;
			end
			S_J: begin
				if (ph_q == 2'd2 && div_done) begin
					j_q <= qsat_w;
				end
			end
			S_C: begin
				if (ph_q == 2'd1) begin
					c_q <= fmul_w;
				end
			end
			S_IMP: begin
				if (ph_q == 2'd1) begin
					imp_q[k_q] <= fmul_w;
				end
			end
			S_CV: begin
				if (ph_q == 2'd1) begin
					cv_q[k_q] <= fmul_w;
				end
			end
			S_VA: begin
				if (ph_q == 2'd1) begin
					a_q.v[k_q] <= cis_pkg::sat32(cis_pkg::SATW'($signed(a_q.v[k_q])) -
					                             cis_pkg::SATW'(fmul_w));
				end
			end
			S_VB: begin
				if (ph_q == 2'd1) begin
					b_q.v[k_q] <= cis_pkg::sat32(cis_pkg::SATW'($signed(b_q.v[k_q])) +
					                             cis_pkg::SATW'(fmul_w));
				end
			end
			S_PA: begin
				if (ph_q == 2'd2 && div_done) begin
					a_q.p[k_q] <= cis_pkg::sat32(cis_pkg::SATW'($signed(a_q.p[k_q])) -
					                             cis_pkg::SATW'(qsat_w));
				end
			end
			S_PB: begin
				if (ph_q == 2'd2 && div_done) begin
					b_q.p[k_q] <= cis_pkg::sat32(cis_pkg::SATW'($signed(b_q.p[k_q])) +
					                             cis_pkg::SATW'(qsat_w));
				end
			end
			S_SAME: begin
				// Same body twice: B starts from A's updated entry.
				if (ia_q == ib_q) begin
					b_q.v <= a_q.v;
					b_q.p <= a_q.p;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign done   = done_q;
	assign status = status_q;
	assign out_x  = out_x_q;
	assign out_y  = out_y_q;
	assign out_z  = out_z_q;

endmodule

@@ hw/rtl/cis_checker.sv @@
// Port-level checker for the contact impulse solver, bound to the top level.
`include "assert_macros.svh"

module cis_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [31:0]                out_x,
	input logic signed [31:0]                out_y,
	input logic signed [31:0]                out_z,
	input logic [1:0]                        status
);

	// Only a result word with done status carries a nonzero vector.
	`CIS_ASSERT_CLK(a_zero_vec, (done && status != cis_pkg::ST_DONE) |-> (out_x == 0 && out_y == 0 && out_z == 0), "nonzero vector with error status")

	// A result word appears only with the block idle.
	`CIS_ASSERT_CLK(a_done_idle, done |-> !busy, "result while busy")

	// Busy rises only after a start.
	`CIS_ASSERT_CLK(a_busy_start, $rose(busy) |-> $past(start), "busy without start")

	// Leaving busy always delivers a result word.
	`CIS_ASSERT_CLK(a_fall_done, $fell(busy) |-> done, "command ended without result")

endmodule

bind contact_impulse_solver_top cis_checker u_cis_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the contact impulse solver top level.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [2:0]  CMD_SPARE_A = 3'd6;
	localparam logic [2:0]  CMD_SPARE_B = 3'd7;
	localparam cis_pkg::q_t ONE         = 32'sd65536;
	localparam int          PHASES      = 6;
	localparam int          PHASE_WORDS = 185;

	// random phase registers; count 5 and percent 1 mean a random value
	localparam int unsigned CNT_SET [PHASES]  = '{256, 8, 0, 1, 5, 256};
	localparam int unsigned PCT_SET [PHASES]  = '{65536, 0, 13107, 1, 0, 65536};
	localparam int unsigned SLOP_SET [PHASES] = '{0, 65536, 655, 0, 65536, 0};

	typedef struct packed {
		cis_pkg::q_t x;
		cis_pkg::q_t y;
		cis_pkg::q_t z;
		logic [1:0]  st;
	} resp_t;

	typedef struct {
		bit          is_cfg;
		bit          typed;
		logic [2:0]  c;
		logic [7:0]  ia;
		logic [7:0]  ib;
		cis_pkg::q_t x;
		cis_pkg::q_t y;
		cis_pkg::q_t z;
		cis_pkg::q_t pen;
		resp_t       exp_r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] cmd = '0;
	logic [7:0] index_a = '0;
	logic [7:0] index_b = '0;
	logic signed [31:0] value_x = '0;
	logic signed [31:0] value_y = '0;
	logic signed [31:0] value_z = '0;
	logic signed [31:0] penetration = '0;
	logic cfg_we = 1'b0;
	logic [cis_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cis_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [1:0] status;

	// body table mirror and register copies
	longint vel [256][3];
	longint pos [256][3];
	longint imass [256];
	longint resti [256];
	bit     is_fixed [256];
	bit     has_v [256];
	bit     has_p [256];
	bit     has_m [256];
	int unsigned n_bodies;
	longint pct;
	longint slop;

	resp_t pending_words[$];
	row_t  dir_rows[$];
	int    errors = 0;
	int    burst_left = 0;
	bit    no_gaps = 1'b0;

	always #5 clk = ~clk;

	contact_impulse_solver_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .index_a(index_a), .index_b(index_b),
		.value_x(value_x), .value_y(value_y), .value_z(value_z),
		.penetration(penetration),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
	);

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// fixed-point product, floor shift, then saturate
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> cis_pkg::FRAC_BITS);
	endfunction

	// Update the mirror for one accepted word and return its result word.
	task automatic resolve_word(input logic [2:0] c, input logic [7:0] ia,
			input logic [7:0] ib, input longint vx, input longint vy,
			input longint vz, input longint pn, output resp_t r);
		longint val[3];
		longint res[3];
		longint vn, ma, mb, msum, e, gain, j, over, cc;
		longint imp[3];
		longint cv[3];
		logic [1:0] st;
		val[0] = vx;
		val[1] = vy;
		val[2] = vz;
		res = '{0, 0, 0};
		st = cis_pkg::ST_DONE;
		if (c <= cis_pkg::CMD_LOAD_PROP || c == cis_pkg::CMD_READ_V ||
				c == cis_pkg::CMD_READ_P) begin
			if (ia >= n_bodies) begin
				st = cis_pkg::ST_BAD;
			end else begin
				case (c)
					cis_pkg::CMD_LOAD_V: begin
						vel[ia] = val;
						has_v[ia] = 1'b1;
					end
					cis_pkg::CMD_LOAD_P: begin
						pos[ia] = val;
						has_p[ia] = 1'b1;
					end
					cis_pkg::CMD_LOAD_PROP: begin
						imass[ia] = vx;
						resti[ia] = vy;
						is_fixed[ia] = (vz != 0);
						has_m[ia] = 1'b1;
					end
					cis_pkg::CMD_READ_V: res = vel[ia];
					default: res = pos[ia];
				endcase
			end
		end else if (c == cis_pkg::CMD_SOLVE) begin
			if (ia >= n_bodies || ib >= n_bodies) begin
				st = cis_pkg::ST_BAD;
			end else begin
				vn = 0;
				ma = imass[ia];
				mb = imass[ib];
				msum = ma + mb;
				for (int k = 0; k < 3; k++)
					vn += (clamp32(vel[ib][k] - vel[ia][k]) * val[k]) >>> cis_pkg::FRAC_BITS;
				vn = clamp32(vn);
				if (vn > 0) begin
					st = cis_pkg::ST_SEP;
				end else if (msum == 0) begin
					st = cis_pkg::ST_ZERO;
				end else begin
					e = (resti[ia] < resti[ib]) ? resti[ia] : resti[ib];
					gain = clamp32(ONE + e);
					j = clamp32((gain * -vn) / msum);
					over = pn - slop;
					if (over < 0) over = 0;
					cc = qmul(over, pct);
					for (int k = 0; k < 3; k++) begin
						imp[k] = qmul(val[k], j);
						cv[k] = qmul(val[k], cc);
					end
					// A first, then B, so a self-contact sees its own update
					for (int k = 0; k < 3; k++)
						vel[ia][k] = clamp32(vel[ia][k] - qmul(imp[k], ma));
					for (int k = 0; k < 3; k++)
						vel[ib][k] = clamp32(vel[ib][k] + qmul(imp[k], mb));
					if (!is_fixed[ia])
						for (int k = 0; k < 3; k++)
							pos[ia][k] = clamp32(pos[ia][k] - clamp32((cv[k] * ma) / msum));
					if (!is_fixed[ib])
						for (int k = 0; k < 3; k++)
							pos[ib][k] = clamp32(pos[ib][k] + clamp32((cv[k] * mb) / msum));
				end
			end
		end
		r.x = res[0][31:0];
		r.y = res[1][31:0];
		r.z = res[2][31:0];
		r.st = st;
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// Check each result word against the oldest expectation.
	always @(posedge clk) begin
		resp_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				w = pending_words.pop_front();
				if (out_x !== w.x) report_mismatch($sformatf("out_x %h exp %h", out_x, w.x));
				if (out_y !== w.y) report_mismatch($sformatf("out_y %h exp %h", out_y, w.y));
				if (out_z !== w.z) report_mismatch($sformatf("out_z %h exp %h", out_z, w.z));
				if (status !== w.st)
					report_mismatch($sformatf("status %0d exp %0d", status, w.st));
			end
		end
	end

	// Drive one word, hold it until taken, then record the expectation.
	task automatic send_word(input row_t rw);
		resp_t r;
		start <= 1'b1;
		cmd <= rw.c;
		index_a <= rw.ia;
		index_b <= rw.ib;
		value_x <= rw.x;
		value_y <= rw.y;
		value_z <= rw.z;
		penetration <= rw.pen;
		do @(posedge clk); while (busy);
		resolve_word(rw.c, rw.ia, rw.ib, longint'(rw.x), longint'(rw.y),
			longint'(rw.z), longint'(rw.pen), r);
		pending_words.insert(pending_words.size(), rw.typed ? rw.exp_r : r);
		// bursts of back-to-back words, then a random gap
		if (burst_left > 0 || no_gaps) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	// Drain outstanding words, then write one register.
	task automatic write_reg(input logic [cis_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[cis_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cis_pkg::CFG_BODY_COUNT: n_bodies = 32'(data[8:0]);
			cis_pkg::CFG_PERCENT: pct = 64'(data[16:0]);
			default: slop = 64'(data[16:0]);
		endcase
	endtask

	function automatic void add_row(input logic [2:0] c, input logic [7:0] ia,
			input logic [7:0] ib, input cis_pkg::q_t x, input cis_pkg::q_t y,
			input cis_pkg::q_t z, input cis_pkg::q_t pn, input bit typed, input resp_t er);
		row_t rw;
		rw.is_cfg = 1'b0;
		rw.typed = typed;
		rw.c = c;
		rw.ia = ia;
		rw.ib = ib;
		rw.x = x;
		rw.y = y;
		rw.z = z;
		rw.pen = pn;
		rw.exp_r = er;
		dir_rows.insert(dir_rows.size(), rw);
	endfunction

	function automatic void add_cfg(input logic [cis_pkg::CFG_IDX_W-1:0] idx,
			input cis_pkg::q_t data);
		row_t rw;
		rw = '{default: '0};
		rw.is_cfg = 1'b1;
		rw.ia = 8'(idx);
		rw.x = data;
		dir_rows.insert(dir_rows.size(), rw);
	endfunction

	// mostly modest Q16.16 values, sometimes full range
	function automatic cis_pkg::q_t rand_q(input int unsigned span);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $signed($urandom_range(0, 2 * span)) - $signed(span);
	endfunction

	// random index biased to a small pool so contacts share bodies
	function automatic logic [7:0] rand_index();
		if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	// Build a random word; reads and solves of unloaded entries become loads.
	function automatic row_t rand_word();
		row_t rw;
		int sel;
		int unsigned pick;
		rw = '{default: '0};
		rw.ia = rand_index();
		rw.ib = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : rand_index();
		rw.x = rand_q(4 << 16);
		rw.y = rand_q(4 << 16);
		rw.z = rand_q(4 << 16);
		rw.pen = rand_q(2 << 16);
		sel = $urandom_range(0, 99);
		if (sel < 12) rw.c = cis_pkg::CMD_LOAD_V;
		else if (sel < 20) rw.c = cis_pkg::CMD_LOAD_P;
		else if (sel < 30) rw.c = cis_pkg::CMD_LOAD_PROP;
		else if (sel < 75) rw.c = cis_pkg::CMD_SOLVE;
		else if (sel < 85) rw.c = cis_pkg::CMD_READ_V;
		else if (sel < 96) rw.c = cis_pkg::CMD_READ_P;
		else rw.c = sel[0] ? CMD_SPARE_A : CMD_SPARE_B;
		if (rw.c == cis_pkg::CMD_SOLVE) begin
			// unit axis normal most of the time
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 2);
				rw.x = (pick == 0) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
				rw.y = (pick == 1) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
				rw.z = (pick == 2) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
			end
			if (rw.ia < n_bodies && !(has_v[rw.ia] && has_p[rw.ia] && has_m[rw.ia]))
				rw.ib = rw.ia;
			else if (rw.ib < n_bodies && !(has_v[rw.ib] && has_p[rw.ib] && has_m[rw.ib]))
				rw.ia = rw.ib;
			if (rw.ia < n_bodies && rw.ia == rw.ib && !has_v[rw.ia])
				rw.c = cis_pkg::CMD_LOAD_V;
			else if (rw.ia < n_bodies && rw.ia == rw.ib && !has_p[rw.ia])
				rw.c = cis_pkg::CMD_LOAD_P;
			else if (rw.ia < n_bodies && rw.ia == rw.ib && !has_m[rw.ia])
				rw.c = cis_pkg::CMD_LOAD_PROP;
			if (rw.c != cis_pkg::CMD_SOLVE) rw.ib = 8'($urandom_range(0, 255));
		end
		if (rw.ia < n_bodies && rw.c == cis_pkg::CMD_READ_V && !has_v[rw.ia])
			rw.c = cis_pkg::CMD_LOAD_V;
		if (rw.ia < n_bodies && rw.c == cis_pkg::CMD_READ_P && !has_p[rw.ia])
			rw.c = cis_pkg::CMD_LOAD_P;
		if (rw.c == cis_pkg::CMD_LOAD_PROP) begin
			sel = $urandom_range(0, 19);
			if (sel < 3) rw.x = 0;
			else if (sel < 8) rw.x = ONE;
			else if (sel < 10) rw.x = -$signed($urandom_range(0, 2 << 16));
			else if (sel == 10) rw.x = $urandom;
			else rw.x = $urandom_range(0, 4 << 16);
			rw.y = ($urandom_range(0, 9) == 0) ? cis_pkg::q_t'($urandom)
			                                    : cis_pkg::q_t'($urandom_range(0, ONE));
			rw.z = ($urandom_range(0, 3) == 0) ? cis_pkg::q_t'($urandom | 1) : cis_pkg::q_t'(0);
		end
		return rw;
	endfunction

	// stimulus
	initial begin
		row_t rw;
		resp_t bad;
		resp_t ok;
		bad = '{x: 0, y: 0, z: 0, st: cis_pkg::ST_BAD};
		ok = '{x: 0, y: 0, z: 0, st: cis_pkg::ST_DONE};
		n_bodies = 0;
		pct = cis_pkg::RESET_PERCENT;
		slop = cis_pkg::RESET_SLOP;
		foreach (has_v[i]) begin
			has_v[i] = 1'b0;
			has_p[i] = 1'b0;
			has_m[i] = 1'b0;
		end

		// table: reset state, extremes, each command and each special case
		add_row(cis_pkg::CMD_READ_V, 0, 0, 0, 0, 0, 0, 1, bad);
		add_row(cis_pkg::CMD_SOLVE, 0, 0, 0, 0, 0, 0, 1, bad);
		add_cfg(cis_pkg::CFG_BODY_COUNT, 4);
		add_row(cis_pkg::CMD_LOAD_V, 0, 8'hff, 32'h7fffffff, 32'h80000000, 0, 0, 1, ok);
		add_row(cis_pkg::CMD_LOAD_P, 0, 0, 1, 2, 3, 0, 1, ok);
		add_row(cis_pkg::CMD_LOAD_PROP, 0, 0, ONE, 32'h8000, 0, 0, 1, ok);
		add_row(cis_pkg::CMD_READ_V, 0, 0, 0, 0, 0, 0, 1,
			'{x: 32'h7fffffff, y: 32'h80000000, z: 0, st: cis_pkg::ST_DONE});
		add_row(cis_pkg::CMD_LOAD_V, 1, 0, 0, 0, -ONE, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_P, 1, 0, -5, 6, 32'h7fffffff, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_PROP, 1, 0, ONE, ONE, 1, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_V, 4, 0, 1, 1, 1, 0, 1, bad);
		add_row(cis_pkg::CMD_READ_P, 255, 0, 0, 0, 0, 0, 1, bad);
		add_row(CMD_SPARE_A, 0, 0, -1, -1, -1, -1, 1, ok);
		add_row(CMD_SPARE_B, 255, 255, 32'h7fffffff, 0, 0, 0, 1, ok);
		add_row(cis_pkg::CMD_SOLVE, 0, 1, 0, 0, ONE, ONE, 0, ok);
		add_row(cis_pkg::CMD_SOLVE, 0, 1, 0, 0, ONE, 32'h7fffffff, 0, ok);
		add_row(cis_pkg::CMD_READ_V, 1, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_READ_P, 0, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_READ_P, 1, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_V, 2, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_P, 2, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_LOAD_PROP, 2, 0, 0, 0, 0, 0, 0, ok);
		add_row(cis_pkg::CMD_SOLVE, 2, 2, ONE, 0, 0, ONE, 1,
			'{x: 0, y: 0, z: 0, st: cis_pkg::ST_ZERO});
		add_row(cis_pkg::CMD_SOLVE, 0, 0, 32'h80000000, 0, 0, 32'h80000000, 0, ok);
		add_row(cis_pkg::CMD_SOLVE, 1, 4, ONE, 0, 0, 0, 1, bad);

		// hold reset, then release on a clock edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].ia[cis_pkg::CFG_IDX_W-1:0], dir_rows[i].x);
			else send_word(dir_rows[i]);
		end

		// random phases, each under its own register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(cis_pkg::CFG_BODY_COUNT,
				CNT_SET[ph] == 5 ? $urandom_range(2, 256) : CNT_SET[ph]);
			write_reg(cis_pkg::CFG_PERCENT,
				PCT_SET[ph] == 1 ? $urandom_range(0, 65536) : PCT_SET[ph]);
			write_reg(cis_pkg::CFG_SLOP, (ph == 4) ? $urandom_range(0, 65536) : SLOP_SET[ph]);
			no_gaps = (ph == 3);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				rw = rand_word();
				send_word(rw);
			end
		end

		// drain, then allow for a stray late word
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0) begin
			$display("contact_impulse_solver_top test passed");
		end else begin
			$display("contact_impulse_solver_top test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("contact_impulse_solver_top test failed");
		$finish;
	end

endmodule
